/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ctcg_pkg.sv */
package ctcg_pkg;

    localparam int CoordW   = 8;
    localparam int ExtW     = 9;
    localparam int StrW     = 10;
    localparam int ElemW    = 27;
    localparam int NodeW    = 25;
    localparam int CntW     = 20;
    localparam int SlotW    = 5;
    localparam int NumTet   = 6;
    localparam int NumFace  = 6;
    localparam int CfgIdxW  = 2;
    localparam int InDataW  = 3 * CoordW;
    localparam int OutDataW = ((ElemW + 4 * NodeW + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_CELLS_X = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_CELLS_Y = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_CELLS_Z = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_state;

    // Steps of the shared multiplier sequence
    typedef enum logic [2:0] {
        OP_HZ,
        OP_NODE,
        OP_ZH,
        OP_ROW,
        OP_ELEM,
        OP_PLANE,
        OP_DONE
    } t_op;

    typedef struct packed {
        logic [StrW-1:0]  a;
        logic [ElemW-1:0] b;
    } t_mul_req;

    typedef logic [2:0] t_corner;

    localparam t_corner TET_CORNER [NumTet][4] = '{
        '{3'd0, 3'd1, 3'd5, 3'd7},
        '{3'd0, 3'd1, 3'd3, 3'd7},
        '{3'd0, 3'd2, 3'd3, 3'd7},
        '{3'd0, 3'd2, 3'd6, 3'd7},
        '{3'd0, 3'd4, 3'd6, 3'd7},
        '{3'd0, 3'd4, 3'd5, 3'd7}
    };

    // Two triangles per face: x-low, x-high, y-low, y-high, z-low, z-high
    localparam t_corner FACE_TRI [NumFace][2][3] = '{
        '{'{3'd0, 3'd2, 3'd6}, '{3'd0, 3'd6, 3'd4}},
        '{'{3'd1, 3'd5, 3'd7}, '{3'd1, 3'd7, 3'd3}},
        '{'{3'd0, 3'd5, 3'd1}, '{3'd0, 3'd4, 3'd5}},
        '{'{3'd2, 3'd3, 3'd7}, '{3'd2, 3'd7, 3'd6}},
        '{'{3'd0, 3'd3, 3'd2}, '{3'd0, 3'd1, 3'd3}},
        '{'{3'd4, 3'd7, 3'd5}, '{3'd4, 3'd6, 3'd7}}
    };

    // Node index of a cube corner from the corner-0 node and the y and z strides
    function automatic logic [NodeW-1:0] corner_node(
        input logic [NodeW-1:0] base,
        input logic [NodeW-1:0] stride_y,
        input logic [NodeW-1:0] stride_z,
        input t_corner          c
    );
        logic [NodeW-1:0] add_y;
        logic [NodeW-1:0] add_z;
        add_y = c[1] ? stride_y : '0;
        add_z = c[2] ? stride_z : '0;
        return base + add_y + add_z + NodeW'(c[0]);
    endfunction

endpackage

/* rtl/ctcg_mul.sv */
module ctcg_mul (
    input  logic                     i_clk,
    input  ctcg_pkg::t_mul_req       i_req,
    output logic [ctcg_pkg::ElemW-1:0] o_prod
);
    import ctcg_pkg::*;

    localparam int FullW = StrW + ElemW;

    logic [FullW-1:0] s_full;
    logic [ElemW-1:0] r_prod;

    // Multiply, keep the low bits only (all users work modulo the field width)
    assign s_full = FullW'(i_req.a) * FullW'(i_req.b);

    always_ff @(posedge i_clk) begin
        r_prod <= s_full[ElemW-1:0];
    end

    assign o_prod = r_prod;

endmodule

/* rtl/ctcg_seq.sv */
`include "assert_macros.svh"

module ctcg_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ctcg_pkg::ExtW-1:0]     i_ext_w,
    input  logic [ctcg_pkg::ExtW-1:0]     i_ext_h,
    input  logic [ctcg_pkg::ExtW-1:0]     i_ext_d,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ctcg_pkg::InDataW-1:0]  i_in_data,
    input  logic                          i_in_first,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ctcg_pkg::OutDataW-1:0] o_out_data,
    output logic                          o_out_kind,
    output logic                          o_out_last,
    output ctcg_pkg::t_mul_req            o_mul_req,
    input  logic [ctcg_pkg::ElemW-1:0]    i_mul_prod
);
    import ctcg_pkg::*;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [SlotW-1:0]  r_slot, n_slot;
    logic [CntW-1:0]   r_bcnt, n_bcnt;
    logic              r_out_valid, n_out_valid;

    logic [CoordW-1:0] r_x, r_y, r_z;
    logic [NumFace-1:0] r_touch;
    logic [NodeW-1:0]  r_node0;
    logic [NodeW-1:0]  r_plane;
    logic [ElemW-1:0]  r_elem;

    logic              r_out_kind;
    logic              r_out_last;
    logic [ElemW-1:0]  r_out_elem;
    logic [NodeW-1:0]  r_out_node [4];

    logic [CoordW-1:0] s_in_x, s_in_y, s_in_z;
    logic              s_accept;
    logic              s_inside;
    logic [StrW-1:0]   s_w1, s_h1;
    logic              s_is_tet;
    logic [SlotW-1:0]  s_fslot;
    logic [2:0]        s_face;
    logic              s_tri;
    logic [NumFace-1:0] s_later;
    logic              s_active;
    logic              s_last;
    logic              s_out_free;
    logic              s_out_load;
    t_corner           s_corner [4];
    logic [NodeW-1:0]  s_node [4];
    logic [ElemW-1:0]  s_elem;

    assign s_in_x = i_in_data[CoordW-1:0];
    assign s_in_y = i_in_data[2*CoordW-1:CoordW];
    assign s_in_z = i_in_data[3*CoordW-1:2*CoordW];

    assign o_in_ready = (r_state == ST_IDLE);
    assign s_accept   = i_in_valid && o_in_ready;
    assign s_inside   = ({1'b0, s_in_x} < i_ext_w) && ({1'b0, s_in_y} < i_ext_h) &&
                        ({1'b0, s_in_z} < i_ext_d);

    assign s_w1 = {1'b0, i_ext_w} + StrW'(1);
    assign s_h1 = {1'b0, i_ext_h} + StrW'(1);

    // Decode the current result slot: six tetrahedra, then two triangles per face
    always_comb begin
        s_is_tet = (r_slot < SlotW'(NumTet));
        s_fslot  = r_slot - SlotW'(NumTet);
        s_face   = s_is_tet ? 3'd0 : s_fslot[3:1];
        s_tri    = s_fslot[0];
        s_later  = r_touch >> (s_face + 3'd1);
        s_active = s_is_tet || r_touch[s_face];
        if (s_is_tet) begin
            s_last = (r_slot == SlotW'(NumTet - 1)) && (r_touch == '0);
        end else begin
            s_last = s_tri && (s_later == '0);
        end
        for (int k = 0; k < 4; k++) begin
            if (s_is_tet) begin
                s_corner[k] = TET_CORNER[r_slot[2:0]][k];
            end else if (k < 3) begin
                s_corner[k] = FACE_TRI[s_face][s_tri][k];
            end else begin
                s_corner[k] = '0;
            end
            s_node[k] = corner_node(r_node0, NodeW'(s_w1), r_plane, s_corner[k]);
        end
        if (!s_is_tet) begin
            s_node[3] = '0;
        end
        s_elem = s_is_tet ? (r_elem + ElemW'(r_slot)) : ElemW'(r_bcnt);
    end

    assign s_out_free = !r_out_valid || i_out_ready;

    // Drive the shared multiplier for each step of the sequence
    always_comb begin
        o_mul_req = '0;
        if (r_state == ST_CALC) begin
            case (r_op)
                OP_HZ: begin
                    o_mul_req.a = s_h1;
                    o_mul_req.b = ElemW'(r_z);
                end
                OP_NODE: begin
                    o_mul_req.a = s_w1;
                    o_mul_req.b = ElemW'(r_y) + i_mul_prod;
                end
                OP_ZH: begin
                    o_mul_req.a = StrW'(i_ext_h);
                    o_mul_req.b = ElemW'(r_z);
                end
                OP_ROW: begin
                    o_mul_req.a = StrW'(i_ext_w);
                    o_mul_req.b = ElemW'(r_y) + i_mul_prod;
                end
                OP_ELEM: begin
                    o_mul_req.a = StrW'(NumTet);
                    o_mul_req.b = ElemW'(r_x) + i_mul_prod;
                end
                OP_PLANE: begin
                    o_mul_req.a = s_w1;
                    o_mul_req.b = ElemW'(s_h1);
                end
                default: begin
                    o_mul_req = '0;
                end
            endcase
        end
    end

    // Next state and control
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_slot      = r_slot;
        n_bcnt      = r_bcnt;
        n_out_valid = r_out_valid && !i_out_ready;
        s_out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (i_in_first) begin
                        n_bcnt = '0;
                    end
                    if (s_inside) begin
                        n_state = ST_CALC;
                        n_op    = OP_HZ;
                    end
                end
            end
            ST_CALC: begin
                if (r_op == OP_DONE) begin
                    n_state = ST_EMIT;
                    n_slot  = '0;
                end else begin
                    n_op = t_op'(r_op + 3'd1);
                end
            end
            ST_EMIT: begin
                if (!s_active) begin
                    n_slot = r_slot + SlotW'(1);
                end else if (s_out_free) begin
                    s_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_slot      = r_slot + SlotW'(1);
                    if (!s_is_tet) begin
                        n_bcnt = r_bcnt + CntW'(1);
                    end
                    if (s_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_HZ;
            r_slot      <= '0;
            r_bcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_slot      <= n_slot;
            r_bcnt      <= n_bcnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Cell data, sequence results and the output register
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x        <= s_in_x;
            r_y        <= s_in_y;
            r_z        <= s_in_z;
            r_touch[0] <= (s_in_x == '0);
            r_touch[1] <= ({1'b0, s_in_x} == i_ext_w - ExtW'(1));
            r_touch[2] <= (s_in_y == '0);
            r_touch[3] <= ({1'b0, s_in_y} == i_ext_h - ExtW'(1));
            r_touch[4] <= (s_in_z == '0);
            r_touch[5] <= ({1'b0, s_in_z} == i_ext_d - ExtW'(1));
        end
        if (r_state == ST_CALC) begin
            case (r_op)
                OP_ZH:    r_node0 <= NodeW'(i_mul_prod) + NodeW'(r_x);
                OP_PLANE: r_elem  <= i_mul_prod;
                OP_DONE:  r_plane <= NodeW'(i_mul_prod);
                default: begin
                end
            endcase
        end
        if (s_out_load) begin
            r_out_kind <= !s_is_tet;
            r_out_last <= s_last;
            r_out_elem <= s_elem;
            for (int k = 0; k < 4; k++) begin
                r_out_node[k] <= s_node[k];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {{(OutDataW - ElemW - 4 * NodeW){1'b0}}, r_out_node[3],
                          r_out_node[2], r_out_node[1], r_out_node[0], r_out_elem};

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid && $stable(o_out_data), "stalled result dropped or changed")
    `ASSERT_SAME(a_tri_no_fourth, i_clk, i_rst_n, r_out_valid && r_out_kind, r_out_node[3] == '0, "triangle carries a fourth node")
    `ASSERT_NEXT(a_first_clears, i_clk, i_rst_n, s_accept && i_in_first, r_bcnt == '0, "first cell did not clear the triangle counter")

endmodule

/* rtl/cuboid_tetra_connectivity_gen_core.sv */
// Each cell inside the grid is accepted, runs the shared-multiplier steps, then walks
// its result slots (6 tetrahedra plus 2 per face position up to the last touched face),
// one slot per cycle while the output is free; no new cell is taken until the last result
// of the current one is loaded. A cell outside the grid is accepted and produces nothing.
// Reset (synchronous, active low): extents return to 1, triangle counter to 0,
// sequencer idle and output empty.
module cuboid_tetra_connectivity_gen_core #(
    parameter int MAX_EXTENT = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ctcg_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [ctcg_pkg::ExtW-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cell_x [7:0], cell_y [15:8], cell_z [23:16]
    input  logic [ctcg_pkg::InDataW-1:0]    s_axis_tdata,
    // first_cell [0]
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // element_number [26:0], node_a [51:27], node_b [76:52], node_c [101:77],
    // node_d [126:102], zero [127]
    output logic [ctcg_pkg::OutDataW-1:0]   m_axis_tdata,
    // kind [0]
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);
    import ctcg_pkg::*;

    localparam int LimW = 11;
    localparam logic [LimW-1:0] ExtLimit = LimW'(MAX_EXTENT);

    logic [ExtW-1:0] r_cells_x, r_cells_y, r_cells_z;
    logic [ExtW-1:0] s_ext_w, s_ext_h, s_ext_d;
    t_mul_req        s_mul_req;
    logic [ElemW-1:0] s_mul_prod;

    // Take zero as one and cap at the largest supported extent
    function automatic logic [ExtW-1:0] clamp_ext(input logic [ExtW-1:0] v);
        logic [ExtW-1:0] res;
        if (v == '0) begin
            res = ExtW'(1);
        end else if (LimW'(v) > ExtLimit) begin
            res = ExtLimit[ExtW-1:0];
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Extent registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= ExtW'(1);
            r_cells_y <= ExtW'(1);
            r_cells_z <= ExtW'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_CELLS_X: r_cells_x <= i_cfg_wdata;
                REG_CELLS_Y: r_cells_y <= i_cfg_wdata;
                REG_CELLS_Z: r_cells_z <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_ext_w = clamp_ext(r_cells_x);
    assign s_ext_h = clamp_ext(r_cells_y);
    assign s_ext_d = clamp_ext(r_cells_z);

    ctcg_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (s_mul_req),
        .o_prod (s_mul_prod)
    );

    ctcg_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ext_w     (s_ext_w),
        .i_ext_h     (s_ext_h),
        .i_ext_d     (s_ext_d),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_first  (s_axis_tuser[0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser[0]),
        .o_out_last  (m_axis_tlast),
        .o_mul_req   (s_mul_req),
        .i_mul_prod  (s_mul_prod)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
    import ctcg_pkg::*;

    localparam int MaxExtent     = 256;
    localparam int DrainCycles   = 40;
    localparam int WatchdogLimit = 4000;
    localparam int HoldCycles    = 300;
    localparam int ItemsPerPhase = 55;

    // Index with no register behind it
    localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

    // Tetrahedra around the corner 0 to corner 7 diagonal
    localparam int TET_TAB [6][4] = '{
        '{0, 1, 5, 7}, '{0, 1, 3, 7}, '{0, 2, 3, 7},
        '{0, 2, 6, 7}, '{0, 4, 6, 7}, '{0, 4, 5, 7}
    };

    // Two triangles per face: x-low, x-high, y-low, y-high, z-low, z-high
    localparam int FACE_TAB [6][2][3] = '{
        '{'{0, 2, 6}, '{0, 6, 4}},
        '{'{1, 5, 7}, '{1, 7, 3}},
        '{'{0, 5, 1}, '{0, 4, 5}},
        '{'{2, 3, 7}, '{2, 7, 6}},
        '{'{0, 3, 2}, '{0, 1, 3}},
        '{'{4, 7, 5}, '{4, 6, 7}}
    };

    typedef struct packed {
        logic        kind;
        logic [26:0] elem;
        logic [24:0] node_a;
        logic [24:0] node_b;
        logic [24:0] node_c;
        logic [24:0] node_d;
        logic        last;
    } t_mesh_elem;

    // Predicts the element stream of each cell and checks the DUT against it
    class mesh_scoreboard;
        logic [ExtW-1:0] ext_reg [3];
        logic [19:0]     tri_count;
        t_mesh_elem      pending_elems [$];
        int              n_err;

        function new();
            ext_reg   = '{9'd1, 9'd1, 9'd1};
            tri_count = '0;
            n_err     = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [ExtW-1:0] val);
            if (idx == REG_CELLS_X) ext_reg[0] = val;
            else if (idx == REG_CELLS_Y) ext_reg[1] = val;
            else if (idx == REG_CELLS_Z) ext_reg[2] = val;
        endfunction

        function int unsigned eff_extent(logic [ExtW-1:0] raw);
            if (raw == 0) return 1;
            if (raw > MaxExtent) return MaxExtent;
            return int'(raw);
        endfunction

        // Queue the tetrahedra and boundary triangles of one accepted cell
        function void add_cell_elements(logic [7:0] x, logic [7:0] y, logic [7:0] z,
                                        logic first);
            longint unsigned w, h, d, base, lx, ly, lz;
            longint unsigned nd [8];
            bit              touch [6];
            t_mesh_elem      e;
            if (first) tri_count = '0;
            w  = eff_extent(ext_reg[0]);
            h  = eff_extent(ext_reg[1]);
            d  = eff_extent(ext_reg[2]);
            lx = longint'(x);
            ly = longint'(y);
            lz = longint'(z);
            if (lx >= w || ly >= h || lz >= d) return;
            for (int c = 0; c < 8; c++) begin
                nd[c] = lx + (c & 1)
                      + (w + 1) * (ly + ((c >> 1) & 1) + (h + 1) * (lz + ((c >> 2) & 1)));
            end
            base = 6 * ((lz * h + ly) * w + lx);
            for (int m = 0; m < 6; m++) begin
                e.kind   = 1'b0;
                e.elem   = 27'(base + m);
                e.node_a = 25'(nd[TET_TAB[m][0]]);
                e.node_b = 25'(nd[TET_TAB[m][1]]);
                e.node_c = 25'(nd[TET_TAB[m][2]]);
                e.node_d = 25'(nd[TET_TAB[m][3]]);
                e.last   = 1'b0;
                pending_elems = {pending_elems, e};
            end
            touch[0] = (lx == 0);
            touch[1] = (lx == w - 1);
            touch[2] = (ly == 0);
            touch[3] = (ly == h - 1);
            touch[4] = (lz == 0);
            touch[5] = (lz == d - 1);
            for (int f = 0; f < 6; f++) begin
                if (touch[f]) begin
                    for (int t = 0; t < 2; t++) begin
                        e.kind   = 1'b1;
                        e.elem   = 27'(tri_count);
                        e.node_a = 25'(nd[FACE_TAB[f][t][0]]);
                        e.node_b = 25'(nd[FACE_TAB[f][t][1]]);
                        e.node_c = 25'(nd[FACE_TAB[f][t][2]]);
                        e.node_d = '0;
                        e.last   = 1'b0;
                        pending_elems = {pending_elems, e};
                        tri_count = tri_count + 1'b1;
                    end
                end
            end
            pending_elems[pending_elems.size() - 1].last = 1'b1;
        endfunction

        // Compare one output transaction with the oldest queued element
        function void check_element(logic [OutDataW-1:0] data, logic kind, logic last);
            t_mesh_elem want;
            t_mesh_elem got;
            if (pending_elems.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected element: tdata %h kind %b last %b",
                                          data, kind, last);
                return;
            end
            want       = pending_elems.pop_front();
            got.kind   = kind;
            got.elem   = data[26:0];
            got.node_a = data[51:27];
            got.node_b = data[76:52];
            got.node_c = data[101:77];
            got.node_d = data[126:102];
            got.last   = last;
            if (got.kind != want.kind || got.elem != want.elem ||
                got.node_a != want.node_a || got.node_b != want.node_b ||
                got.node_c != want.node_c || got.node_d != want.node_d ||
                got.last != want.last) begin
                n_err++;
                if (n_err <= 10) begin
                    $display("element mismatch: exp kind %0d num %0d nodes %0d %0d %0d %0d last %0d",
                             want.kind, want.elem, want.node_a, want.node_b,
                             want.node_c, want.node_d, want.last);
                    $display("                  act kind %0d num %0d nodes %0d %0d %0d %0d last %0d",
                             got.kind, got.elem, got.node_a, got.node_b,
                             got.node_c, got.node_d, got.last);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CfgIdxW-1:0]   i_cfg_index;
    logic [ExtW-1:0]      i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [InDataW-1:0]   s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OutDataW-1:0]  m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    mesh_scoreboard sb = new();

    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_len;
    int stall_cycles;

    cuboid_tetra_connectivity_gen_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive the output ready: long hold-off first, else random stalls
    always @(negedge i_clk) begin
        if (rx_hold_len > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_len   <= rx_hold_len - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Check output transactions and watch for a stalled run
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_element(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WatchdogLimit) begin
                $display("watchdog: no transaction for %0d cycles", stall_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Offer one cell after a random idle gap and hold it until accepted
    task automatic send_cell(logic [7:0] x, logic [7:0] y, logic [7:0] z, logic first);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.add_cell_elements(x, y, z, first);
    endtask

    // Drop the input and wait until every queued element has come out
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_elems.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ExtW-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_grid(logic [ExtW-1:0] ex, logic [ExtW-1:0] ey, logic [ExtW-1:0] ez);
        wait_idle();
        write_reg(REG_CELLS_X, ex);
        write_reg(REG_CELLS_Y, ey);
        write_reg(REG_CELLS_Z, ez);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [ExtW-1:0] pick_extent();
        case ($urandom_range(5))
            0, 1: return 9'($urandom_range(1, 4));
            2: return 9'd256;
            3: return $urandom_range(1) ? 9'd0 : 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(1, 256));
        endcase
    endfunction

    // Start coordinate, often close to the high side so rows wrap
    function automatic logic [7:0] pick_start(int unsigned ext);
        if (ext > 4 && $urandom_range(1)) return 8'(ext - $urandom_range(1, 3));
        return 8'($urandom_range(ext - 1));
    endfunction

    // Walk cells in raster order with stray cells mixed in
    task automatic run_segment(int n);
        int unsigned w, h, d;
        logic [7:0]  x, y, z, nx, ny, nz;
        logic        first;
        w = sb.eff_extent(sb.ext_reg[0]);
        h = sb.eff_extent(sb.ext_reg[1]);
        d = sb.eff_extent(sb.ext_reg[2]);
        x = pick_start(w);
        y = pick_start(h);
        z = pick_start(d);
        first = ($urandom_range(9) < 7);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(4) == 0) begin
                if ($urandom_range(1)) begin
                    nx = 8'($urandom_range(w - 1));
                    ny = 8'($urandom_range(h - 1));
                    nz = 8'($urandom_range(d - 1));
                end else begin
                    nx = 8'($urandom_range(255));
                    ny = 8'($urandom_range(255));
                    nz = 8'($urandom_range(255));
                end
                send_cell(nx, ny, nz, ($urandom_range(7) == 0));
            end else begin
                send_cell(x, y, z, first);
                first = 1'b0;
                if (x + 1 < w) begin
                    x++;
                end else begin
                    x = '0;
                    if (y + 1 < h) begin
                        y++;
                    end else begin
                        y = '0;
                        z = (z + 1 < d) ? z + 1'b1 : 8'd0;
                    end
                end
            end
        end
    endtask

    // Run one random segment and add its length to the phase total
    task automatic run_counted(inout int sent);
        int n;
        n = $urandom_range(6, 16);
        run_segment(n);
        sent += n;
    endtask

    initial begin
        int sent;
        int seg;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        rx_hold_len   = 0;
        stall_cycles  = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset grid of one cell: every face is a boundary
        send_cell(8'd0, 8'd0, 8'd0, 1'b1);
        send_cell(8'd1, 8'd0, 8'd0, 1'b0);
        send_cell(8'd0, 8'd0, 8'd0, 1'b0);
        // Cell outside the grid still clears the counter
        send_cell(8'd0, 8'd5, 8'd0, 1'b1);
        send_cell(8'd0, 8'd0, 8'd0, 1'b0);

        // Zero extents read as one; a write to the spare index is dropped
        wait_idle();
        write_reg(REG_CELLS_X, 9'd0);
        write_reg(REG_CELLS_Y, 9'd0);
        write_reg(REG_CELLS_Z, 9'd0);
        write_reg(REG_UNUSED, 9'h1ff);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        send_cell(8'd0, 8'd0, 8'd0, 1'b1);

        // Oversized extents clamp to the maximum grid
        set_grid(9'd511, 9'd300, 9'd257);
        send_cell(8'd0, 8'd0, 8'd0, 1'b1);
        send_cell(8'd255, 8'd255, 8'd255, 1'b0);
        send_cell(8'd255, 8'd0, 8'd128, 1'b0);
        send_cell(8'd0, 8'd255, 8'd255, 1'b0);
        send_cell(8'd128, 8'd128, 8'd0, 1'b1);

        // Full raster pass over a small grid
        set_grid(9'd3, 9'd2, 9'd2);
        for (int i = 0; i < 12; i++)
            send_cell(8'(i % 3), 8'((i / 3) % 2), 8'(i / 6), (i == 0));

        // Random phases with different idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
                default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
            endcase
            sent = 0;
            seg  = 0;
            while (sent < ItemsPerPhase) begin
                set_grid(pick_extent(), pick_extent(), pick_extent());
                // Hold the output off so the block backs up into its input
                if (ph == 0 && seg == 1) begin
                    @(posedge i_clk);
                    rx_hold_len = HoldCycles;
                end
                run_counted(sent);
                seg++;
            end
        end

        wait_idle();
        if (sb.pending_elems.size() != 0)
            $display("%0d elements never arrived", sb.pending_elems.size());
        if (sb.n_err == 0 && sb.pending_elems.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
